FILE: rtl/npsrch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npsrch_pkg: shared types and constants for the next prime search
// Sequencer states, the factor start and step, the smallest prime and the result field width.
// ----------------------------------------------------------------------------
package npsrch_pkg;

    localparam int OUT_WIDTH    = 32;
    localparam int FIRST_FACTOR = 3;
    localparam int FACTOR_STEP  = 2;
    localparam int SMALL_PRIME  = 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/npsrch_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npsrch_div: shared restoring divider
// Produces quotient and remainder one bit per cycle.
// ----------------------------------------------------------------------------
module npsrch_div #(
    parameter int W = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_dividend,
    input  wire logic [W-1:0] i_divisor,
    output logic              o_done,
    output logic [W-1:0]      o_quotient,
    output logic [W-1:0]      o_remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W:0]       shifted;
    logic [W:0]       diff;

    assign shifted = {r_rem, r_quo[W-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

FILE: rtl/next_prime_search.sv
`timescale 1ns / 1ps
`default_nettype none
// Timing: starts of 0, 1 and 2 are answered without the divider, in the cycle
//   after the request; otherwise each trial factor takes one run of the shared
//   divider of width W (W = min(WIDTH, 32)), over all factors of all candidates tried.
// Throughput: one request at a time; the next is taken once the result leaves.
// Reset: synchronous, active low; returns to idle and drops any result held.
// ----------------------------------------------------------------------------
// next_prime_search: smallest prime at or above a start value (a start of 0 gives 0)
// Trial division of odd candidates by odd factors up to the square root,
// sequenced over one shared divider. Flags overflow when no prime fits.
// ----------------------------------------------------------------------------
module next_prime_search
    import npsrch_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [OUT_WIDTH-1:0] i_start_value,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [OUT_WIDTH-1:0]      o_prime_found,
    output logic                      o_overflow
);

    localparam int CW = (WIDTH > OUT_WIDTH) ? OUT_WIDTH : WIDTH;
    localparam logic [CW-1:0] LIM = {CW{1'b1}};

    t_state        r_state, n_state;
    logic [CW-1:0] r_cand,  n_cand;
    logic [CW-1:0] r_fac,   n_fac;
    logic          r_ovf,   n_ovf;

    logic          div_start;
    logic          div_done;
    logic [CW-1:0] div_quo;
    logic [CW-1:0] div_rem;
    logic [CW-1:0] start_w;

    assign start_w = i_start_value[CW-1:0];

    npsrch_div #(
        .W (CW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_cand),
        .i_divisor   (r_fac),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        r_fac  <= n_fac;
        r_ovf  <= n_ovf;
    end

    always_comb begin
        n_state   = r_state;
        n_cand    = r_cand;
        n_fac     = r_fac;
        n_ovf     = r_ovf;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_ovf = 1'b0;
                    n_fac = CW'(FIRST_FACTOR);
                    if (start_w <= CW'(SMALL_PRIME)) begin
                        n_cand  = (start_w == '0) ? '0 : CW'(SMALL_PRIME);
                        n_state = S_DONE;
                    end else begin
                        n_cand  = start_w | CW'(1);
                        n_state = S_DIV_START;
                    end
                end
            end
            S_DIV_START: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    if (r_fac > div_quo) begin
                        n_state = S_DONE;
                    end else if (div_rem == '0) begin
                        if (r_cand == LIM) begin
                            n_ovf   = 1'b1;
                            n_cand  = '0;
                            n_state = S_DONE;
                        end else begin
                            n_cand  = r_cand + CW'(FACTOR_STEP);
                            n_fac   = CW'(FIRST_FACTOR);
                            n_state = S_DIV_START;
                        end
                    end else begin
                        n_fac   = r_fac + CW'(FACTOR_STEP);
                        n_state = S_DIV_START;
                    end
                end
            end
            S_DONE: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_DONE);
    assign o_prime_found = OUT_WIDTH'(r_cand);
    assign o_overflow    = r_ovf;

endmodule
`default_nettype wire
